// ===== src/cple_pkg.sv =====
`default_nettype none
package cple_pkg;

  localparam int REQ_BITS        = 3;
  localparam int STATUS_BITS     = 2;
  localparam int KEY_PORT_BITS   = 16;
  localparam int COUNT_PORT_BITS = 7;

  localparam logic [REQ_BITS-1:0] REQ_APPEND  = 3'd0;
  localparam logic [REQ_BITS-1:0] REQ_DELETE  = 3'd1;
  localparam logic [REQ_BITS-1:0] REQ_NEXT    = 3'd2;
  localparam logic [REQ_BITS-1:0] REQ_PREV    = 3'd3;
  localparam logic [REQ_BITS-1:0] REQ_CURRENT = 3'd4;

  localparam logic [STATUS_BITS-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_BITS-1:0] STAT_EMPTY     = 2'd1;
  localparam logic [STATUS_BITS-1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [STATUS_BITS-1:0] STAT_FULL      = 2'd3;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SWEEP,
    FSM_FINISH
  } fsm_t;

  typedef struct packed {
    logic shift;
    logic feed_valid;
  } ring_ctl_t;

endpackage
`default_nettype wire

// ===== src/cple_cell.sv =====
`default_nettype none
module cple_cell #(
  parameter int KW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          shift,
  input  wire logic          nb_valid,
  input  wire logic [KW-1:0] nb_song,
  output logic               valid,
  output logic [KW-1:0]      song
);

  logic          valid_r;
  logic [KW-1:0] song_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift) begin
      valid_r <= nb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      song_r <= nb_song;
    end
  end

  assign valid = valid_r;
  assign song  = song_r;

endmodule
`default_nettype wire

// ===== src/cple_ctrl.sv =====
`default_nettype none
module cple_ctrl #(
  parameter int N  = 64,
  parameter int KW = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [cple_pkg::REQ_BITS-1:0]       in_req_type,
  input  wire logic [cple_pkg::KEY_PORT_BITS-1:0]  in_song_key,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [cple_pkg::STATUS_BITS-1:0]         out_status,
  output logic [cple_pkg::KEY_PORT_BITS-1:0]       out_cursor_song,
  output logic [cple_pkg::COUNT_PORT_BITS-1:0]     out_entry_count,
  input  wire logic                                c0_valid,
  input  wire logic [KW-1:0]                       c0_song,
  input  wire logic                                c1_valid,
  input  wire logic [KW-1:0]                       c1_song,
  output cple_pkg::ring_ctl_t                      ctl,
  output logic [KW-1:0]                            feed_song
);
  import cple_pkg::*;

  localparam int PW = $clog2(N);
  localparam int CW = $clog2(N + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(N);
  localparam logic [PW-1:0] LAST_STEP  = PW'(N - 1);

  fsm_t                   state_r, state_nxt;
  logic [PW-1:0]          k_r, k_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [PW-1:0]          cur_r, cur_nxt;
  logic [REQ_BITS-1:0]    req_r, req_nxt;
  logic [KW-1:0]          key_r, key_nxt;
  logic [PW-1:0]          tgt_r, tgt_nxt;
  logic                   found_r, found_nxt;
  logic [PW-1:0]          m_r, m_nxt;
  logic [KW-1:0]          cap_r, cap_nxt;
  logic [KW-1:0]          head_r, head_nxt;
  logic [STATUS_BITS-1:0] status_r, status_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [STATUS_BITS-1:0] out_status_r, out_status_nxt;
  logic [KW-1:0]          out_song_r, out_song_nxt;
  logic [CW-1:0]          out_count_r, out_count_nxt;

  logic          is_del, append_ok, match, drop, last, list_empty;
  logic [PW-1:0] mm, cnt_m1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      cur_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cur_r       <= cur_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    req_r        <= req_nxt;
    key_r        <= key_nxt;
    tgt_r        <= tgt_nxt;
    m_r          <= m_nxt;
    cap_r        <= cap_nxt;
    head_r       <= head_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_song_r   <= out_song_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign list_empty = (count_r == '0);
  assign cnt_m1     = PW'(count_r - 1'b1);
  assign is_del     = (req_r == REQ_DELETE);
  assign append_ok  = (req_r == REQ_APPEND) && (count_r != FULL_COUNT);
  assign match      = is_del && !found_r && c0_valid && (c0_song == key_r);
  assign drop       = found_r || match;
  assign last       = (k_r == LAST_STEP);
  assign mm         = match ? k_r : m_r;

  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    count_nxt      = count_r;
    cur_nxt        = cur_r;
    req_nxt        = req_r;
    key_nxt        = key_r;
    tgt_nxt        = tgt_r;
    found_nxt      = found_r;
    m_nxt          = m_r;
    cap_nxt        = cap_r;
    head_nxt       = head_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_song_nxt   = out_song_r;
    out_count_nxt  = out_count_r;
    ctl.shift      = 1'b0;
    ctl.feed_valid = 1'b0;
    feed_song      = c0_song;
    in_ready       = (state_r == FSM_IDLE);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      FSM_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_req_type;
          key_nxt    = in_song_key[KW-1:0];
          k_nxt      = '0;
          found_nxt  = 1'b0;
          tgt_nxt    = cur_r;
          status_nxt = list_empty ? STAT_EMPTY : STAT_OK;
          unique case (in_req_type)
            REQ_APPEND: begin
              if (count_r == FULL_COUNT) begin
                status_nxt = STAT_FULL;
              end else begin
                status_nxt = STAT_OK;
                if (list_empty) tgt_nxt = '0;
              end
            end
            REQ_DELETE: begin
              if (!list_empty) status_nxt = STAT_NOT_FOUND;
            end
            REQ_NEXT: begin
              if (!list_empty) tgt_nxt = (cur_r == cnt_m1) ? '0 : PW'(cur_r + 1'b1);
            end
            REQ_PREV: begin
              if (!list_empty) tgt_nxt = (cur_r == '0) ? cnt_m1 : PW'(cur_r - 1'b1);
            end
            REQ_CURRENT: begin
            end
            default: begin
              status_nxt = STAT_OK;
            end
          endcase
          state_nxt = FSM_SWEEP;
        end
      end

      FSM_SWEEP: begin
        ctl.shift = 1'b1;
        if (append_ok && (CW'(k_r) == count_r)) begin
          ctl.feed_valid = 1'b1;
          feed_song      = key_r;
        end else if (drop) begin
          ctl.feed_valid = last ? 1'b0 : c1_valid;
          feed_song      = c1_song;
        end else begin
          ctl.feed_valid = c0_valid;
          feed_song      = c0_song;
        end

        if (k_r == '0) head_nxt = feed_song;

        if (!is_del) begin
          if (k_r == tgt_r) cap_nxt = feed_song;
        end else if (!drop) begin
          if (k_r == cur_r) cap_nxt = feed_song;
        end else if (((cur_r > mm) && (k_r == PW'(cur_r - 1'b1))) ||
                     ((cur_r == mm) && (k_r == cur_r))) begin
          cap_nxt = feed_song;
        end

        if (match) begin
          found_nxt  = 1'b1;
          m_nxt      = k_r;
          status_nxt = STAT_OK;
        end

        k_nxt = PW'(k_r + 1'b1);
        if (last) state_nxt = FSM_FINISH;
      end

      FSM_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_song_nxt   = cap_r;
          if (append_ok) begin
            count_nxt = CW'(count_r + 1'b1);
            cur_nxt   = tgt_r;
          end else if (is_del && found_r) begin
            count_nxt = CW'(count_r - 1'b1);
            if (cur_r > m_r) begin
              cur_nxt = PW'(cur_r - 1'b1);
            end else if ((cur_r == m_r) && (m_r == cnt_m1)) begin
              cur_nxt      = '0;
              out_song_nxt = head_r;
            end
            if (count_r == CW'(1)) cur_nxt = '0;
          end else if (!is_del) begin
            cur_nxt = tgt_r;
          end
          if (count_nxt == '0) out_song_nxt = '0;
          out_count_nxt = count_nxt;
          state_nxt     = FSM_IDLE;
        end
      end

      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_cursor_song = KEY_PORT_BITS'(out_song_r);
  assign out_entry_count = COUNT_PORT_BITS'(out_count_r);

endmodule
`default_nettype wire

// ===== src/circular_playlist_list_engine_unit.sv =====
`default_nettype none
// Playlist kept as an ordered row of POOL_ENTRIES cells, head in cell 0; a request rotates the
// whole row once through the controller, which appends at the tail, drops the first matching
// entry (closing the gap by feeding from the second cell), and picks up the song under the
// cursor on the way. An item is accepted, the row is rotated one step per cell, and the result
// is posted, plus any wait for out_ready. The next item can be accepted once the result is
// posted, while that result may still wait.
module circular_playlist_list_engine_unit #(
  parameter int POOL_ENTRIES = 64,
  parameter int KEY_BITS     = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [cple_pkg::REQ_BITS-1:0]       in_req_type,
  input  wire logic [cple_pkg::KEY_PORT_BITS-1:0]  in_song_key,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [cple_pkg::STATUS_BITS-1:0]         out_status,
  output logic [cple_pkg::KEY_PORT_BITS-1:0]       out_cursor_song,
  output logic [cple_pkg::COUNT_PORT_BITS-1:0]     out_entry_count
);
  import cple_pkg::*;

  localparam int KW = (KEY_BITS < KEY_PORT_BITS) ? KEY_BITS : KEY_PORT_BITS;

  ring_ctl_t     ctl;
  logic [KW-1:0] feed_song;
  logic          valid_w [POOL_ENTRIES];
  logic [KW-1:0] song_w  [POOL_ENTRIES];

  genvar i;
  generate
    for (i = 0; i < POOL_ENTRIES; i++) begin : g_cell
      if (i == POOL_ENTRIES - 1) begin : g_last
        cple_cell #(.KW(KW)) u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .shift    (ctl.shift),
          .nb_valid (ctl.feed_valid),
          .nb_song  (feed_song),
          .valid    (valid_w[i]),
          .song     (song_w[i])
        );
      end else begin : g_mid
        cple_cell #(.KW(KW)) u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .shift    (ctl.shift),
          .nb_valid (valid_w[i+1]),
          .nb_song  (song_w[i+1]),
          .valid    (valid_w[i]),
          .song     (song_w[i])
        );
      end
    end
  endgenerate

  cple_ctrl #(.N(POOL_ENTRIES), .KW(KW)) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_song_key     (in_song_key),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_cursor_song (out_cursor_song),
    .out_entry_count (out_entry_count),
    .c0_valid        (valid_w[0]),
    .c0_song         (song_w[0]),
    .c1_valid        (valid_w[1]),
    .c1_song         (song_w[1]),
    .ctl             (ctl),
    .feed_song       (feed_song)
  );

endmodule
`default_nettype wire
